FILE: sv/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising edge outside reset
`define SWCD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("swcd assertion failed");

// condition must never be seen outside reset
`define SWCD_NEVER(lbl, clk, rst_n, cond) \
  `SWCD_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define SWCD_ASSERT(lbl, clk, rst_n, prop)
`define SWCD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: sv/swcd_pkg.sv
package swcd_pkg;

  localparam int NumCh        = 4;
  localparam int SampleW      = 16;
  localparam int RingDepthDef = 64;
  localparam int WindowDef    = 60;
  localparam int AvgDivisor   = 60;
  localparam int NumRegs      = 8;
  localparam int CfgIdxW      = $clog2(NumRegs);
  localparam int CfgDataW     = 16;

  // transaction kinds
  localparam logic KindPush = 1'b0;
  localparam logic KindEval = 1'b1;

  typedef logic [SampleW-1:0] sample_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_OFFSET,
    REG_CURRENT_OFFSET,
    REG_HIGH_PRESS_OFFSET,
    REG_LOW_PRESS_OFFSET,
    REG_TEMP_THRESHOLD,
    REG_CURRENT_THRESHOLD,
    REG_HIGH_PRESS_THRESHOLD,
    REG_LOW_PRESS_THRESHOLD
  } cfg_reg_t;

endpackage

FILE: sv/swcd_ram.sv
module swcd_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/sensor_window_change_detector.sv
// sensor window change detector
// input channel (in_valid / in_stall): one transaction is either a push of four
// raw samples (temperature, current, high and low pressure) or an evaluate.
// a push corrects each sample by its offset register, writes the four results
// into the sample ring and updates the running window sums; it gives no result.
// an evaluate gives one result transaction on the output channel
// (out_valid / out_stall): four window averages (sum / 60, saturated) and the
// changed flag, or the newest corrected samples with changed forced when
// in_use_latest is set.
// throughput: one transaction per cycle while in_stall is low, pushes and evaluates
// mixed freely; the ring writes on each accepted push and reads on each accepted one.
// path: an accepted evaluate passes the ring read, the reciprocal multiply in stage 1
// and the compare in stage 2, then the output register drives it onto out_*.
// reset: synchronous, active low; clears offsets, thresholds, sums, previous
// averages and the write pointer. the ring gets no clearing pass: the write
// pointer and a wrap flag mark which entries were written; unwritten ones read as zero.
// in_stall is high during reset.
// stall: a result waiting on out_stall holds; pushes still go in, and an
// evaluate that would need the output stage stalls the input.
// configuration: cfg_we writes cfg_data to register cfg_index; write idle only (not enforced by the block).

`include "assert_macros.svh"

module sensor_window_change_detector #(
  parameter int RING_DEPTH = swcd_pkg::RingDepthDef,
  parameter int WINDOW     = swcd_pkg::WindowDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [swcd_pkg::SampleW-1:0] in_temp_sample,
  input  logic [swcd_pkg::SampleW-1:0] in_current_sample,
  input  logic [swcd_pkg::SampleW-1:0] in_high_press_sample,
  input  logic [swcd_pkg::SampleW-1:0] in_low_press_sample,
  input  logic                         in_use_latest,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [swcd_pkg::SampleW-1:0] out_temp_average,
  output logic [swcd_pkg::SampleW-1:0] out_current_average,
  output logic [swcd_pkg::SampleW-1:0] out_high_press_average,
  output logic [swcd_pkg::SampleW-1:0] out_low_press_average,
  output logic                         out_changed,
  // configuration
  input  logic                          cfg_we,
  input  logic [swcd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swcd_pkg::CfgDataW-1:0] cfg_data
);

  localparam int NumCh   = swcd_pkg::NumCh;
  localparam int SampleW = swcd_pkg::SampleW;
  localparam int RamW    = NumCh * SampleW;
  localparam int AW      = $clog2(RING_DEPTH);

  // channel lanes in a ring entry
  localparam int ChTemp  = 0;
  localparam int ChCurr  = 1;
  localparam int ChHigh  = 2;
  localparam int ChLow   = 3;

  // window longer than the ring is cut to the ring
  localparam int EffWindow = (WINDOW < RING_DEPTH) ? WINDOW : RING_DEPTH;
  localparam int SumW      = SampleW + $clog2(EffWindow + 1);

  // exact division by the constant: floor(n * m / 2^k) with m = ceil(2^k / d)
  localparam int DivLog     = $clog2(swcd_pkg::AvgDivisor);
  localparam int RecipShift = SumW + DivLog;
  localparam longint unsigned RecipFull =
    ((64'd1 << RecipShift) + swcd_pkg::AvgDivisor - 1) / swcd_pkg::AvgDivisor;
  localparam int RecipW = RecipShift - DivLog + 1;
  localparam int ProdW  = SumW + RecipW;
  localparam int QW     = ProdW - RecipShift;
  localparam int QW2    = (QW > SampleW) ? QW : SampleW;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);

  localparam logic [AW:0]   DepthW   = (AW + 1)'(RING_DEPTH);
  localparam logic [AW:0]   LeaveOfs = (AW + 1)'(RING_DEPTH - EffWindow);
  localparam logic [AW-1:0] LastAddr = AW'(RING_DEPTH - 1);
  localparam logic [QW2-1:0] SatLimit = QW2'({SampleW{1'b1}});

  // configuration registers
  logic [NumCh-1:0][SampleW-1:0] offset_r;
  logic [NumCh-1:0][SampleW-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      thresh_r <= '0;
    end else if (cfg_we) begin
      unique case (swcd_pkg::cfg_reg_t'(cfg_index))
        swcd_pkg::REG_TEMP_OFFSET:          offset_r[ChTemp] <= cfg_data;
        swcd_pkg::REG_CURRENT_OFFSET:       offset_r[ChCurr] <= cfg_data;
        swcd_pkg::REG_HIGH_PRESS_OFFSET:    offset_r[ChHigh] <= cfg_data;
        swcd_pkg::REG_LOW_PRESS_OFFSET:     offset_r[ChLow]  <= cfg_data;
        swcd_pkg::REG_TEMP_THRESHOLD:       thresh_r[ChTemp] <= cfg_data;
        swcd_pkg::REG_CURRENT_THRESHOLD:    thresh_r[ChCurr] <= cfg_data;
        swcd_pkg::REG_HIGH_PRESS_THRESHOLD: thresh_r[ChHigh] <= cfg_data;
        swcd_pkg::REG_LOW_PRESS_THRESHOLD:  thresh_r[ChLow]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_r, s1_eval_r, s1_latest_r, s1_rd_ok_r;
  logic s2_valid_r, s2_latest_r;
  logic out_valid_r;
  logic out_hold, s2_hold, s1_hold, in_accept;

  assign out_hold  = out_valid_r && out_stall;
  assign s2_hold   = s2_valid_r && out_hold;
  // only an evaluate needs the later stages; a push always retires in stage 1
  assign s1_hold   = s1_valid_r && s1_eval_r && s2_hold;
  assign in_stall  = !rst_n || s1_hold;
  assign in_accept = in_valid && !in_stall;

  // write pointer and fill marker
  logic [AW-1:0] wi_r, wi_nxt;
  logic          wrapped_r;
  logic [AW:0]   leave_sum;
  logic [AW-1:0] leave_addr, newest_addr, rd_addr;
  logic          rd_ok;
  logic          do_push;

  assign do_push     = in_accept && (in_kind == swcd_pkg::KindPush);
  assign leave_sum   = {1'b0, wi_r} + LeaveOfs;
  assign leave_addr  = (leave_sum >= DepthW) ? AW'(leave_sum - DepthW) : AW'(leave_sum);
  assign newest_addr = (wi_r == '0) ? LastAddr : wi_r - 1'b1;
  // push reads the sample leaving the window, evaluate the newest sample
  assign rd_addr     = (in_kind == swcd_pkg::KindPush) ? leave_addr : newest_addr;
  // entries are written in order, so anything at or past the pointer is
  // unwritten until the first wrap
  assign rd_ok       = wrapped_r || (rd_addr < wi_r);
  assign wi_nxt      = (wi_r == LastAddr) ? '0 : wi_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (do_push) begin
      wi_r <= wi_nxt;
      if (wi_r == LastAddr) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  // offset correction, wraps at 16 bits
  logic [NumCh-1:0][SampleW-1:0] corr;
  assign corr[ChTemp] = in_temp_sample - offset_r[ChTemp];
  assign corr[ChCurr] = in_current_sample + offset_r[ChCurr];
  assign corr[ChHigh] = in_high_press_sample + offset_r[ChHigh];
  assign corr[ChLow]  = in_low_press_sample + offset_r[ChLow];

  // sample ring, written on an accepted push, read-first on collision
  logic [RamW-1:0] ram_rdata;

  swcd_ram #(
    .Width (RamW),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (do_push),
    .waddr (wi_r),
    .wdata (corr),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // stage 1: ring data back, sum update or reciprocal multiply
  logic [NumCh-1:0][SampleW-1:0] s1_corr_r;
  logic [NumCh-1:0][SampleW-1:0] ring_lane;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_eval_r   <= (in_kind == swcd_pkg::KindEval);
      s1_latest_r <= in_use_latest;
      s1_rd_ok_r  <= rd_ok;
      s1_corr_r   <= corr;
    end
  end

  // unwritten entries read as zero
  assign ring_lane = s1_rd_ok_r ? ram_rdata : '0;

  logic [NumCh-1:0][SumW-1:0] sums_r;
  logic [NumCh-1:0][ProdW-1:0] prod;
  logic [NumCh-1:0][QW2-1:0]   s2_q_nxt;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      prod[c]     = ProdW'(sums_r[c]) * ProdW'(Recip);
      s2_q_nxt[c] = s1_latest_r ? QW2'(ring_lane[c])
                                : QW2'(prod[c][ProdW-1:RecipShift]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else if (s1_valid_r && !s1_eval_r) begin
      for (int c = 0; c < NumCh; c++) begin
        sums_r[c] <= sums_r[c] - SumW'(ring_lane[c]) + SumW'(s1_corr_r[c]);
      end
    end
  end

  // stage 2: saturate, compare against the previous result
  logic [NumCh-1:0][QW2-1:0] s2_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!s2_hold) begin
      s2_valid_r <= s1_valid_r && s1_eval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s2_hold && s1_valid_r && s1_eval_r) begin
      s2_latest_r <= s1_latest_r;
      s2_q_r      <= s2_q_nxt;
    end
  end

  logic [NumCh-1:0][SampleW-1:0] prev_r;
  logic [NumCh-1:0][SampleW-1:0] val, diff;
  logic [NumCh-1:0]              over;
  logic                          changed_nxt;
  logic                          s2_move;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      val[c]  = (s2_q_r[c] > SatLimit) ? {SampleW{1'b1}} : s2_q_r[c][SampleW-1:0];
      diff[c] = (val[c] >= prev_r[c]) ? val[c] - prev_r[c] : prev_r[c] - val[c];
      over[c] = diff[c] > thresh_r[c];
    end
    changed_nxt = s2_latest_r || (|over);
  end

  assign s2_move = s2_valid_r && !out_hold;

  // every evaluate, the newest-sample kind too, becomes the new reference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (s2_move) begin
      prev_r <= val;
    end
  end

  // output register
  logic [NumCh-1:0][SampleW-1:0] out_val_r;
  logic                          out_changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_hold) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_val_r     <= val;
      out_changed_r <= changed_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_temp_average       = out_val_r[ChTemp];
  assign out_current_average    = out_val_r[ChCurr];
  assign out_high_press_average = out_val_r[ChHigh];
  assign out_low_press_average  = out_val_r[ChLow];
  assign out_changed            = out_changed_r;

  // an evaluate leaving stage 2 always lands in the output register
  `SWCD_ASSERT(a_s2_to_out, clk, rst_n, s2_move |=> out_valid_r)
  // the fill marker only sets as the pointer wraps to zero
  `SWCD_ASSERT(a_wrap_at_zero, clk, rst_n, $rose(wrapped_r) |-> (wi_r == '0))
  // a held evaluate keeps its ring data
  `SWCD_ASSERT(a_hold_keeps_rdata, clk, rst_n, s1_hold |=> $stable(ram_rdata))
  // nothing enters the ring while stage 1 is held
  `SWCD_NEVER(a_no_push_on_hold, clk, rst_n, s1_hold && do_push)

endmodule
